FILE: rtl/mps_pkg.sv
// ============================================================================
// mps_pkg: shared types and constants for the mist pulse scheduler
// Holds the command, owner and register index codes, the field widths and
// the reset values of the configuration registers.
// ============================================================================
`timescale 1ns / 1ps

package mps_pkg;

    localparam int CmdW      = 2;
    localparam int SecondsW  = 3;
    localparam int OwnerW    = 2;
    localparam int IntervalW = 24;
    localparam int PulseW    = 16;
    localparam int TpsW      = 16;
    localparam int LengthW   = 18;
    localparam int CfgIndexW = 2;
    localparam int CfgDataW  = 24;

    localparam logic [CmdW-1:0] CMD_TICK   = 2'd0;
    localparam logic [CmdW-1:0] CMD_MANUAL = 2'd1;
    localparam logic [CmdW-1:0] CMD_AUTO   = 2'd2;

    localparam logic [OwnerW-1:0] OWNER_NONE   = 2'd0;
    localparam logic [OwnerW-1:0] OWNER_MANUAL = 2'd1;
    localparam logic [OwnerW-1:0] OWNER_AUTO   = 2'd2;

    localparam logic [CfgIndexW-1:0] REG_AUTO_INTERVAL = 2'd0;
    localparam logic [CfgIndexW-1:0] REG_AUTO_PULSE    = 2'd1;
    localparam logic [CfgIndexW-1:0] REG_TICKS_PER_SEC = 2'd2;

    localparam logic [IntervalW-1:0] INTERVAL_RESET = 24'd1800000;
    localparam logic [PulseW-1:0]    PULSE_RESET    = 16'd3000;
    localparam logic [TpsW-1:0]      TPS_RESET      = 16'd1000;

    localparam logic [LengthW-1:0] ELAPSED_MAX = 18'h3FFFF;

    typedef struct packed {
        logic              relay_on;
        logic [OwnerW-1:0] pulse_owner;
        logic              auto_active;
        logic              accepted;
        logic              changed;
    } result_t;

endpackage

FILE: rtl/mist_pulse_scheduler.sv
// ============================================================================
// mist_pulse_scheduler: relay pulse timer shared by manual and auto sources
// Each item is a tick, a manual trigger or an auto enable change; each
// produces one status result. State updates in the cycle an item is taken.
// ============================================================================
//
//  Channel  Signals                                   Direction  Handshake
//  item     item_valid item_stall command             in         valid/stall
//           pulse_seconds auto_request
//  result   result_valid result_stall relay_on        out        valid/stall
//           pulse_owner auto_active accepted changed
//  cfg      cfg_valid cfg_ready cfg_index cfg_data    in         valid/ready
//
//  One item is taken per cycle while item_stall is low; its result is registered.
//  Scheduler state updates on the same edge that takes the item.
//  A two-entry output buffer (result register plus skid register) lets a new
//  item enter while a result waits; item_stall rises only when both are full.
//  Reset clears the timer state and loads the default register values.
//  cfg_ready is always high.
//
`timescale 1ns / 1ps

module mist_pulse_scheduler
    import mps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [CmdW-1:0]      command,
    input  logic [SecondsW-1:0]  pulse_seconds,
    input  logic                 auto_request,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 relay_on,
    output logic [OwnerW-1:0]    pulse_owner,
    output logic                 auto_active,
    output logic                 accepted,
    output logic                 changed,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    // Configuration registers.
    logic [IntervalW-1:0] interval_reg;
    logic [PulseW-1:0]    auto_pulse_reg;
    logic [TpsW-1:0]      tps_reg;

    // Scheduler state.
    logic                 running_reg, running_next;
    logic [OwnerW-1:0]    owner_reg, owner_next;
    logic [LengthW-1:0]   elapsed_reg, elapsed_next;
    logic [LengthW-1:0]   length_reg, length_next;
    logic                 auto_en_reg, auto_en_next;
    logic [IntervalW-1:0] countdown_reg, countdown_next;

    // Output buffer.
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    result_t res;

    logic take;
    logic take_item;

    logic [LengthW-1:0]   elapsed_inc;
    logic                 pulse_ends;
    logic                 run_after_end;
    logic [IntervalW-1:0] countdown_dec;
    logic                 auto_start;
    logic                 manual_ok;
    logic [LengthW-1:0]   manual_len;
    logic [LengthW-1:0]   tps_ext;

    assign cfg_ready  = 1'b1;
    assign item_stall = skid_valid_reg;
    assign take_item  = item_valid && !skid_valid_reg;
    assign take       = out_valid_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg   <= INTERVAL_RESET;
            auto_pulse_reg <= PULSE_RESET;
            tps_reg        <= TPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_AUTO_INTERVAL: interval_reg   <= cfg_data;
                REG_AUTO_PULSE:    auto_pulse_reg <= cfg_data[PulseW-1:0];
                REG_TICKS_PER_SEC: tps_reg        <= cfg_data[TpsW-1:0];
                default:           ;
            endcase
        end
    end

    // Tick path: the running pulse is checked for expiry before the auto
    // cycle gets its chance to start a new one.
    always_comb
    begin
        tps_ext     = {{(LengthW-TpsW){1'b0}}, tps_reg};
        elapsed_inc = (elapsed_reg < ELAPSED_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
        pulse_ends  = running_reg && (elapsed_inc >= length_reg);
        run_after_end = running_reg && !pulse_ends;
        countdown_dec = (countdown_reg != '0) ? countdown_reg - 1'b1 : countdown_reg;
        auto_start  = auto_en_reg && (countdown_dec == '0) && !run_after_end;
        manual_ok   = !running_reg && (pulse_seconds >= 3'd1) && (pulse_seconds <= 3'd3);
        case (pulse_seconds[1:0])
            2'd1:    manual_len = tps_ext;
            2'd2:    manual_len = {tps_ext[LengthW-2:0], 1'b0};
            2'd3:    manual_len = {tps_ext[LengthW-2:0], 1'b0} + tps_ext;
            default: manual_len = '0;
        endcase

        running_next   = running_reg;
        owner_next     = owner_reg;
        elapsed_next   = elapsed_reg;
        length_next    = length_reg;
        auto_en_next   = auto_en_reg;
        countdown_next = countdown_reg;
        res            = '0;

        case (command)
            CMD_TICK:
            begin
                if (running_reg)
                begin
                    elapsed_next = elapsed_inc;
                end
                if (pulse_ends)
                begin
                    running_next = 1'b0;
                    owner_next   = OWNER_NONE;
                end
                if (auto_en_reg)
                begin
                    countdown_next = countdown_dec;
                end
                if (auto_start)
                begin
                    running_next   = 1'b1;
                    owner_next     = OWNER_AUTO;
                    length_next    = {{(LengthW-PulseW){1'b0}}, auto_pulse_reg};
                    elapsed_next   = '0;
                    countdown_next = interval_reg;
                end
                res.accepted = auto_start;
                res.changed  = pulse_ends || auto_start;
            end
            CMD_MANUAL:
            begin
                if (manual_ok)
                begin
                    running_next = 1'b1;
                    owner_next   = OWNER_MANUAL;
                    length_next  = manual_len;
                    elapsed_next = '0;
                end
                res.accepted = manual_ok;
                res.changed  = manual_ok;
            end
            CMD_AUTO:
            begin
                if (auto_request != auto_en_reg)
                begin
                    auto_en_next = auto_request;
                    if (auto_request)
                    begin
                        countdown_next = interval_reg;
                    end
                end
                res.accepted = (auto_request != auto_en_reg);
                res.changed  = (auto_request != auto_en_reg);
            end
            default: ;
        endcase

        res.relay_on    = running_next;
        res.pulse_owner = owner_next;
        res.auto_active = auto_en_next;
    end

    // Output buffer steering.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (take_item)
            begin
                out_next = res;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (take_item)
        begin
            if (!out_valid_reg)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            owner_reg      <= OWNER_NONE;
            elapsed_reg    <= '0;
            length_reg     <= '0;
            auto_en_reg    <= 1'b0;
            countdown_reg  <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_item)
            begin
                running_reg   <= running_next;
                owner_reg     <= owner_next;
                elapsed_reg   <= elapsed_next;
                length_reg    <= length_next;
                auto_en_reg   <= auto_en_next;
                countdown_reg <= countdown_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_valid = out_valid_reg;
    assign relay_on     = out_reg.relay_on;
    assign pulse_owner  = out_reg.pulse_owner;
    assign auto_active  = out_reg.auto_active;
    assign accepted     = out_reg.accepted;
    assign changed      = out_reg.changed;

    // The skid register only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without a result in the output register");

    // A running pulse always has an owner, and an idle relay has none.
    a_owner_matches_run: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg == (owner_reg != OWNER_NONE))
        else $error("pulse owner disagrees with running flag");

    // Whatever takes effect changes the reported state.
    a_accept_changes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.accepted) |-> out_reg.changed)
        else $error("accepted result without a state change");

    // A result leaving the buffer is replaced by the skid entry.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (take && skid_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved into the output register");

endmodule

FILE: bench/mist_pulse_scheduler_tb.sv
// ============================================================================
// mist_pulse_scheduler_tb: self-checking bench for the mist pulse scheduler
// Drives tick, manual trigger and auto enable transactions through the item
// channel under several register settings and idle/stall patterns. A local
// model of the shared pulse timer predicts every status result, and each
// result is compared field by field with the oldest prediction.
// ============================================================================
`timescale 1ns / 1ps

module mist_pulse_scheduler_tb;
    import mps_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        logic [CmdW-1:0]     cmd;
        logic [SecondsW-1:0] secs;
        logic                req;
    } sched_item_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    logic [CmdW-1:0]      command = CMD_TICK;
    logic [SecondsW-1:0]  pulse_seconds = '0;
    logic                 auto_request = 1'b0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic                 relay_on;
    logic [OwnerW-1:0]    pulse_owner;
    logic                 auto_active;
    logic                 accepted;
    logic                 changed;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index = REG_AUTO_INTERVAL;
    logic [CfgDataW-1:0]  cfg_data = '0;

    mist_pulse_scheduler i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .command       (command),
        .pulse_seconds (pulse_seconds),
        .auto_request  (auto_request),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .relay_on      (relay_on),
        .pulse_owner   (pulse_owner),
        .auto_active   (auto_active),
        .accepted      (accepted),
        .changed       (changed),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the registers and of the timer state.
    logic [IntervalW-1:0] timer_interval = INTERVAL_RESET;
    logic [PulseW-1:0]    timer_auto_len = PULSE_RESET;
    logic [TpsW-1:0]      timer_tps      = TPS_RESET;
    logic                 timer_running  = 1'b0;
    logic [OwnerW-1:0]    timer_owner    = OWNER_NONE;
    logic [LengthW-1:0]   timer_elapsed  = '0;
    logic [LengthW-1:0]   timer_length   = '0;
    logic                 timer_auto_on  = 1'b0;
    logic [IntervalW-1:0] timer_countdown = '0;

    sched_item_t pending_items[$];
    result_t     status_expected[$];
    logic        item_fire = 1'b0;
    int          sender_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    task automatic flag_error(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [3:0] got, input logic [3:0] want);
        if (got !== want)
            flag_error($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
    endtask

    function automatic logic try_start_pulse(input logic [OwnerW-1:0] owner,
                                             input logic [LengthW-1:0] len);
        if (timer_running)
            return 1'b0;
        timer_running = 1'b1;
        timer_owner   = owner;
        timer_length  = len;
        timer_elapsed = '0;
        return 1'b1;
    endfunction

    function automatic result_t schedule_item(input sched_item_t it);
        result_t            r;
        logic               took;
        logic               moved;
        logic [LengthW-1:0] manual_len;
        took  = 1'b0;
        moved = 1'b0;
        case (it.cmd)
            CMD_TICK:
            begin
                // An expiring pulse ends before a due auto cycle gets its chance.
                if (timer_running)
                begin
                    if (timer_elapsed < ELAPSED_MAX)
                        timer_elapsed = timer_elapsed + 1'b1;
                    if (timer_elapsed >= timer_length)
                    begin
                        timer_running = 1'b0;
                        timer_owner   = OWNER_NONE;
                        moved         = 1'b1;
                    end
                end
                if (timer_auto_on)
                begin
                    if (timer_countdown != 0)
                        timer_countdown = timer_countdown - 1'b1;
                    if (timer_countdown == 0 &&
                        try_start_pulse(OWNER_AUTO, LengthW'(timer_auto_len)))
                    begin
                        timer_countdown = timer_interval;
                        took  = 1'b1;
                        moved = 1'b1;
                    end
                end
            end
            CMD_MANUAL:
            begin
                manual_len = LengthW'(it.secs) * LengthW'(timer_tps);
                if (it.secs >= 1 && it.secs <= 3 && try_start_pulse(OWNER_MANUAL, manual_len))
                begin
                    took  = 1'b1;
                    moved = 1'b1;
                end
            end
            CMD_AUTO:
            begin
                if (it.req != timer_auto_on)
                begin
                    timer_auto_on = it.req;
                    if (it.req)
                        timer_countdown = timer_interval;
                    took  = 1'b1;
                    moved = 1'b1;
                end
            end
            default: ;
        endcase
        r.relay_on    = timer_running;
        r.pulse_owner = timer_owner;
        r.auto_active = timer_auto_on;
        r.accepted    = took;
        r.changed     = moved;
        return r;
    endfunction

    // Item driver: presents the next pending item once the current one is taken.
    always @(negedge clk)
    begin : drive_items
        sched_item_t nxt_item;
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_fire)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                nxt_item      = pending_items.pop_front();
                item_valid    <= 1'b1;
                command       <= nxt_item.cmd;
                pulse_seconds <= nxt_item.secs;
                auto_request  <= nxt_item.req;
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        result_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: predicts on every accepted item and checks every accepted result.
    always @(posedge clk)
    begin : watch_channels
        result_t     want;
        sched_item_t taken;
        if (rst_n && item_valid && !item_stall)
        begin
            taken.cmd  = command;
            taken.secs = pulse_seconds;
            taken.req  = auto_request;
            status_expected.push_back(schedule_item(taken));
        end
        item_fire <= rst_n && item_valid && !item_stall;
        if (rst_n && result_valid && !result_stall)
        begin
            if (status_expected.size() == 0)
                flag_error("result transaction with no prediction waiting");
            else
            begin
                want = status_expected.pop_front();
                check_field("relay_on", 4'(relay_on), 4'(want.relay_on));
                check_field("pulse_owner", 4'(pulse_owner), 4'(want.pulse_owner));
                check_field("auto_active", 4'(auto_active), 4'(want.auto_active));
                check_field("accepted", 4'(accepted), 4'(want.accepted));
                check_field("changed", 4'(changed), 4'(want.changed));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[%0t] ERROR: timeout", $realtime);
            $display("mist_pulse_scheduler_tb failed");
            $finish;
        end
    end

    task automatic push_item(input logic [CmdW-1:0] cmd, input int secs, input logic req);
        sched_item_t it;
        it.cmd  = cmd;
        it.secs = SecondsW'(secs);
        it.req  = req;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_items.size() != 0 || item_valid || status_expected.size() != 0);
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CfgDataW'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_AUTO_INTERVAL: timer_interval = IntervalW'(val);
            REG_AUTO_PULSE:    timer_auto_len = PulseW'(val);
            REG_TICKS_PER_SEC: timer_tps      = TpsW'(val);
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Registers change only with the scheduler idle and every result collected.
    task automatic set_timing(input int unsigned interval, input int unsigned auto_len,
                              input int unsigned tps);
        wait_drained();
        repeat (4) @(posedge clk);
        write_reg(REG_AUTO_INTERVAL, interval);
        write_reg(REG_AUTO_PULSE, auto_len);
        write_reg(REG_TICKS_PER_SEC, tps);
    endtask

    task automatic run_random(input int idle_pct, input int stall_pct, input int count,
                              input int tick_pct);
        sched_item_t it;
        int          roll;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (count)
        begin
            roll    = $urandom_range(99);
            it.secs = SecondsW'($urandom_range(7));
            it.req  = 1'($urandom_range(1));
            if (roll < tick_pct)
                it.cmd = CMD_TICK;
            else if (roll < tick_pct + ((100 - tick_pct) * 2) / 3)
            begin
                it.cmd = CMD_MANUAL;
                // Mostly valid second counts so that manual pulses really start.
                if ($urandom_range(3) != 0)
                    it.secs = SecondsW'($urandom_range(3, 1));
            end
            else
                it.cmd = CMD_AUTO;
            pending_items.push_back(it);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values: only ignored starts and auto enable changes.
        push_item(CMD_AUTO, 0, 1'b0);
        push_item(CMD_MANUAL, 0, 1'b1);
        push_item(CMD_MANUAL, 7, 1'b0);
        push_item(CMD_MANUAL, 4, 1'b1);
        push_item(CMD_AUTO, 0, 1'b1);
        push_item(CMD_AUTO, 5, 1'b1);
        push_item(CMD_TICK, 2, 1'b0);
        push_item(CMD_AUTO, 0, 1'b0);

        // Short timing: pulse ending, a due auto cycle blocked by a manual
        // pulse, retry on the next tick, disable and reload on enable.
        set_timing(2, 2, 1);
        push_item(CMD_TICK, 0, 1'b0);
        push_item(CMD_MANUAL, 3, 1'b0);
        push_item(CMD_AUTO, 0, 1'b1);
        push_item(CMD_TICK, 0, 1'b0);
        push_item(CMD_TICK, 0, 1'b0);
        push_item(CMD_TICK, 0, 1'b0);
        push_item(CMD_MANUAL, 2, 1'b0);
        push_item(CMD_TICK, 0, 1'b0);
        push_item(CMD_TICK, 0, 1'b0);
        push_item(CMD_AUTO, 0, 1'b0);
        push_item(CMD_TICK, 0, 1'b0);
        push_item(CMD_TICK, 0, 1'b0);
        push_item(CMD_AUTO, 0, 1'b1);
        push_item(CMD_MANUAL, 1, 1'b0);
        push_item(CMD_TICK, 0, 1'b0);
        push_item(CMD_TICK, 0, 1'b0);
        push_item(CMD_MANUAL, 6, 1'b1);
        wait_drained();

        set_timing(1, 1, 1);
        run_random(0, 0, 225, 60);

        set_timing($urandom_range(40, 1), $urandom_range(20, 1), $urandom_range(8, 1));
        run_random(72, 0, 225, 60);

        set_timing(24'hFFFFFF, 16'hFFFF, 16'hFFFF);
        run_random(0, 72, 225, 60);

        set_timing($urandom_range(40, 1), $urandom_range(20, 1), $urandom_range(8, 1));
        run_random(18, 18, 225, 65);

        // The second half only starts once every earlier result has come back.
        set_timing($urandom_range(10, 1), $urandom_range(4, 1), $urandom_range(3, 1));
        run_random(0, 0, 110, 55);
        run_random(0, 0, 115, 55);

        set_timing($urandom_range(300, 50), $urandom_range(100, 10), $urandom_range(50, 10));
        run_random(72, 0, 225, 85);

        set_timing($urandom_range(40, 1), $urandom_range(20, 1), $urandom_range(8, 1));
        run_random(0, 72, 225, 60);

        set_timing($urandom_range(40, 1), $urandom_range(20, 1), $urandom_range(8, 1));
        run_random(18, 18, 225, 70);

        repeat (10) @(posedge clk);
        if (status_expected.size() != 0)
            flag_error($sformatf("%0d predicted results never arrived", status_expected.size()));
        if (error_count == 0)
            $display("mist_pulse_scheduler_tb passed");
        else
            $display("mist_pulse_scheduler_tb failed");
        $finish;
    end

endmodule
